// ===== design/mpct_pkg.sv =====
// ----------------------------------------------------------------------------
// mpct_pkg: shared types and constants for the MP config table parser
// Word layouts for both channels, status codes and table layout constants.
// ----------------------------------------------------------------------------
package mpct_pkg;

  // Table layout
  localparam logic [15:0] HDR_LEN   = 16'd44;
  localparam logic [15:0] POS_LEN_LO = 16'd4;
  localparam logic [15:0] POS_LEN_HI = 16'd5;
  localparam logic [15:0] POS_CNT_LO = 16'd34;
  localparam logic [15:0] POS_CNT_HI = 16'd35;
  localparam logic [15:0] POS_LAPIC0 = 16'd36;
  localparam logic [15:0] POS_LAPIC3 = 16'd39;
  localparam logic [4:0]  PROC_LEN  = 5'd20;
  localparam logic [4:0]  OTHER_LEN = 5'd8;

  // Entry field offsets and processor flag bits
  localparam logic [4:0]  OFS_APIC_ID = 5'd1;
  localparam logic [4:0]  OFS_FLAGS   = 5'd3;
  localparam int unsigned FLAG_EN_BIT  = 0;
  localparam int unsigned FLAG_BSP_BIT = 1;
  localparam logic [7:0]  TYPE_PROC   = 8'h00;

  // Result kinds
  localparam logic KIND_CPU  = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  // Closing status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_SIG   = 3'd1;
  localparam logic [2:0] ST_SHORT_LEN = 3'd2;
  localparam logic [2:0] ST_BAD_SUM   = 3'd3;
  localparam logic [2:0] ST_TRUNC     = 3'd4;
  localparam logic [2:0] ST_NO_CPUS   = 3'd5;

  typedef struct packed {
    logic [7:0] table_byte;
    logic       table_start;
  } item_t;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  found_apic_id;
    logic [2:0]  status;
    logic [8:0]  cpu_total;
    logic [7:0]  boot_apic_id;
    logic [31:0] lapic_address;
  } result_t;

  // "PCMP" signature, one byte per header position
  function automatic logic [7:0] sig_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = 8'h50;
      2'd1:    b = 8'h43;
      2'd2:    b = 8'h4D;
      2'd3:    b = 8'h50;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ===== design/mpct_parse.sv =====
// ----------------------------------------------------------------------------
// mpct_parse: per-byte table parser
// Holds the parse state and seen map; computes the state update and the
// optional result word for each accepted byte in one pass.
// ----------------------------------------------------------------------------
module mpct_parse (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  mpct_pkg::item_t   item,
  input  logic [7:0]        default_bsp,
  output logic              res_valid,
  output mpct_pkg::result_t res
);

  // State registers
  logic        active, active_next;
  logic [15:0] byte_position, byte_position_next;
  logic [15:0] base_length, base_length_next;
  logic [15:0] entries_expected, entries_expected_next;
  logic [15:0] entries_done, entries_done_next;
  logic [7:0]  running_sum, running_sum_next;
  logic [4:0]  entry_byte, entry_byte_next;
  logic        entry_is_processor, entry_is_processor_next;
  logic [7:0]  entry_apic_id, entry_apic_id_next;
  logic [255:0] seen_map, seen_map_next;
  logic [8:0]  found_count, found_count_next;
  logic [7:0]  current_bsp, current_bsp_next;
  logic [31:0] apic_address, apic_address_next;
  logic        walk_stopped, walk_stopped_next;
  logic        trunc_flag, trunc_flag_next;

  logic [15:0] pos;
  logic [7:0]  b;
  logic [4:0]  need;
  logic [15:0] left;
  logic [1:0]  lapic_sel;
  logic [2:0]  st;
  logic        close;

  // Step logic
  always_comb begin
    active_next             = active;
    byte_position_next      = byte_position;
    base_length_next        = base_length;
    entries_expected_next   = entries_expected;
    entries_done_next       = entries_done;
    running_sum_next        = running_sum;
    entry_byte_next         = entry_byte;
    entry_is_processor_next = entry_is_processor;
    entry_apic_id_next      = entry_apic_id;
    seen_map_next           = seen_map;
    found_count_next        = found_count;
    current_bsp_next        = current_bsp;
    apic_address_next       = apic_address;
    walk_stopped_next       = walk_stopped;
    trunc_flag_next         = trunc_flag;
    res_valid               = 1'b0;
    res                     = '0;
    b                       = item.table_byte;
    need                    = mpct_pkg::OTHER_LEN;
    left                    = '0;
    lapic_sel               = '0;
    st                      = mpct_pkg::ST_OK;
    close                   = 1'b0;

    // New table: clear the parse state and load the default BSP
    if (item.table_start) begin
      active_next             = 1'b1;
      byte_position_next      = '0;
      base_length_next        = '0;
      entries_expected_next   = '0;
      entries_done_next       = '0;
      running_sum_next        = '0;
      entry_byte_next         = '0;
      entry_is_processor_next = 1'b0;
      entry_apic_id_next      = '0;
      seen_map_next           = '0;
      found_count_next        = '0;
      current_bsp_next        = default_bsp;
      apic_address_next       = '0;
      walk_stopped_next       = 1'b0;
      trunc_flag_next         = 1'b0;
    end

    pos = byte_position_next;

    if (active_next) begin
      running_sum_next = running_sum_next + b;

      // Header fields
      if (pos < 16'd4) begin
        if (b != mpct_pkg::sig_byte(pos[1:0])) begin
          close = 1'b1;
          st    = mpct_pkg::ST_BAD_SIG;
        end
      end else if (pos == mpct_pkg::POS_LEN_LO) begin
        base_length_next = {8'h00, b};
      end else if (pos == mpct_pkg::POS_LEN_HI) begin
        base_length_next = {b, base_length_next[7:0]};
        if (base_length_next < mpct_pkg::HDR_LEN) begin
          close = 1'b1;
          st    = mpct_pkg::ST_SHORT_LEN;
        end
      end else if (pos == mpct_pkg::POS_CNT_LO) begin
        entries_expected_next = {8'h00, b};
      end else if (pos == mpct_pkg::POS_CNT_HI) begin
        entries_expected_next = {b, entries_expected_next[7:0]};
      end else if (pos >= mpct_pkg::POS_LAPIC0 && pos <= mpct_pkg::POS_LAPIC3) begin
        lapic_sel = pos[1:0];
        case (lapic_sel)
          2'd0:    apic_address_next[7:0]   = b;
          2'd1:    apic_address_next[15:8]  = b;
          2'd2:    apic_address_next[23:16] = b;
          2'd3:    apic_address_next[31:24] = b;
          default: apic_address_next        = apic_address_next;
        endcase
      end else if (pos >= mpct_pkg::HDR_LEN && !walk_stopped_next) begin
        // Entry walk
        if (entry_byte_next == 5'd0) begin
          if (entries_done_next >= entries_expected_next) begin
            walk_stopped_next = 1'b1;
          end else begin
            entry_is_processor_next = (b == mpct_pkg::TYPE_PROC);
            need = entry_is_processor_next ? mpct_pkg::PROC_LEN : mpct_pkg::OTHER_LEN;
            left = base_length_next - pos;
            if (left < {11'd0, need}) begin
              trunc_flag_next   = 1'b1;
              walk_stopped_next = 1'b1;
            end else begin
              entry_byte_next = 5'd1;
            end
          end
        end else begin
          need = entry_is_processor_next ? mpct_pkg::PROC_LEN : mpct_pkg::OTHER_LEN;
          if (entry_is_processor_next && entry_byte_next == mpct_pkg::OFS_APIC_ID) begin
            entry_apic_id_next = b;
          end
          if (entry_is_processor_next && entry_byte_next == mpct_pkg::OFS_FLAGS &&
              b[mpct_pkg::FLAG_EN_BIT]) begin
            if (b[mpct_pkg::FLAG_BSP_BIT]) begin
              current_bsp_next = entry_apic_id_next;
            end
            if (!seen_map_next[entry_apic_id_next]) begin
              seen_map_next[entry_apic_id_next] = 1'b1;
              found_count_next                  = found_count_next + 9'd1;
              res_valid                         = 1'b1;
              res.result_kind                   = mpct_pkg::KIND_CPU;
              res.found_apic_id                 = entry_apic_id_next;
            end
          end
          entry_byte_next = entry_byte_next + 5'd1;
          if (entry_byte_next >= need) begin
            entry_byte_next   = 5'd0;
            entries_done_next = entries_done_next + 16'd1;
          end
        end
      end

      // Table end on the last base-table byte
      if (!close && pos >= mpct_pkg::POS_LEN_HI &&
          ({1'b0, pos} + 17'd1) == {1'b0, base_length_next}) begin
        close = 1'b1;
        if (running_sum_next != 8'd0) begin
          st = mpct_pkg::ST_BAD_SUM;
        end else if (trunc_flag_next) begin
          st = mpct_pkg::ST_TRUNC;
        end else if (found_count_next == 9'd0) begin
          st = mpct_pkg::ST_NO_CPUS;
        end else begin
          st = mpct_pkg::ST_OK;
        end
      end

      if (close) begin
        active_next       = 1'b0;
        res_valid         = 1'b1;
        res               = '0;
        res.result_kind   = mpct_pkg::KIND_DONE;
        res.status        = st;
        res.cpu_total     = (st == mpct_pkg::ST_OK) ? found_count_next : 9'd0;
        res.boot_apic_id  = (st == mpct_pkg::ST_OK) ? current_bsp_next : default_bsp;
        res.lapic_address = (st == mpct_pkg::ST_OK || st == mpct_pkg::ST_TRUNC ||
                             st == mpct_pkg::ST_NO_CPUS) ? apic_address_next : 32'd0;
      end else begin
        byte_position_next = pos + 16'd1;
      end
    end
  end

  // State update on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      active             <= 1'b0;
      byte_position      <= '0;
      base_length        <= '0;
      entries_expected   <= '0;
      entries_done       <= '0;
      running_sum        <= '0;
      entry_byte         <= '0;
      entry_is_processor <= 1'b0;
      entry_apic_id      <= '0;
      seen_map           <= '0;
      found_count        <= '0;
      current_bsp        <= '0;
      apic_address       <= '0;
      walk_stopped       <= 1'b0;
      trunc_flag         <= 1'b0;
    end else if (take) begin
      active             <= active_next;
      byte_position      <= byte_position_next;
      base_length        <= base_length_next;
      entries_expected   <= entries_expected_next;
      entries_done       <= entries_done_next;
      running_sum        <= running_sum_next;
      entry_byte         <= entry_byte_next;
      entry_is_processor <= entry_is_processor_next;
      entry_apic_id      <= entry_apic_id_next;
      seen_map           <= seen_map_next;
      found_count        <= found_count_next;
      current_bsp        <= current_bsp_next;
      apic_address       <= apic_address_next;
      walk_stopped       <= walk_stopped_next;
      trunc_flag         <= trunc_flag_next;
    end
  end

endmodule

// ===== design/mpct_out_reg.sv =====
// ----------------------------------------------------------------------------
// mpct_out_reg: result register
// Holds one result word for the downstream side; frees itself in the same
// cycle the word is taken, so the parser stalls only while a word waits unread.
// ----------------------------------------------------------------------------
module mpct_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  logic              load_valid,
  input  mpct_pkg::result_t load_data,
  output logic              space,
  output logic              result_valid,
  input  logic              result_ready,
  output mpct_pkg::result_t result
);

  // Room for a new word when empty or being drained now
  assign space = !result_valid || result_ready;

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= load_valid;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (load && load_valid) begin
      result <= load_data;
    end
  end

endmodule

// ===== design/mp_config_table_cpu_parser_core.sv =====
// ----------------------------------------------------------------------------
// mp_config_table_cpu_parser_core: MP configuration table parser, top level
// Output: a result word is registered, valid the cycle after its byte is taken.
// Throughput: one table byte per cycle; the single result register stalls
// input only while an unread result is held.
// Reset: synchronous rst clears parse state, seen map, result valid flag and
// the default BSP register (to 0). No clearing pass is needed.
// ----------------------------------------------------------------------------
module mp_config_table_cpu_parser_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  mpct_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_ready,
  output mpct_pkg::result_t result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [7:0]        cfg_data
);

  logic              take;
  logic              space;
  logic              res_valid;
  mpct_pkg::result_t res;
  logic [7:0]        default_bsp;

  assign item_ready = space;
  assign take       = item_valid && item_ready;
  assign cfg_ready  = 1'b1;

  // Default BSP register
  always_ff @(posedge clk) begin
    if (rst) begin
      default_bsp <= '0;
    end else if (cfg_valid && cfg_ready) begin
      default_bsp <= cfg_data;
    end
  end

  mpct_parse u_parse (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .item        (item),
    .default_bsp (default_bsp),
    .res_valid   (res_valid),
    .res         (res)
  );

  mpct_out_reg u_out_reg (
    .clk          (clk),
    .rst          (rst),
    .load         (take),
    .load_valid   (res_valid),
    .load_data    (res),
    .space        (space),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule
